// ----- src/rgbled_pkg.sv -----
// Shared types, constants and the gamma table of the RGB LED strip driver.
package rgbled_pkg;

   localparam int MAX_LEDS       = 64;
   localparam int BITS_PER_PIXEL = 24;
   localparam int LED_ADDR_W     = $clog2(MAX_LEDS);
   localparam int LED_POS_W      = $clog2(MAX_LEDS + 1);
   localparam int CNT_W          = (LED_POS_W > 7) ? LED_POS_W : 7;
   localparam int RAM_DEPTH      = 2 * MAX_LEDS;
   localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
   localparam int BIT_POS_W      = $clog2(BITS_PER_PIXEL);

   localparam logic [2:0] OP_WR_FRONT = 3'd0;
   localparam logic [2:0] OP_WR_BACK  = 3'd1;
   localparam logic [2:0] OP_COMMIT   = 3'd2;
   localparam logic [2:0] OP_START    = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   localparam logic [1:0] CSR_HIGH_ONE   = 2'd0;
   localparam logic [1:0] CSR_HIGH_ZERO  = 2'd1;
   localparam logic [1:0] CSR_RESET_PER  = 2'd2;
   localparam logic [1:0] CSR_LED_COUNT  = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_DATA  = 2'd2
   } phase_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_LOAD = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic take;
      logic issue_read;
      logic finish_load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_load;
   } dp_status_type;

   localparam logic [23:0] GAMMA_CURVE [256] = '{
      24'd0, 24'd3, 24'd21, 24'd66, 24'd148, 24'd276, 24'd460, 24'd709,
      24'd1031, 24'd1434, 24'd1926, 24'd2515, 24'd3209, 24'd4015, 24'd4941, 24'd5994,
      24'd7181, 24'd8510, 24'd9987, 24'd11620, 24'd13415, 24'd15378, 24'd17518, 24'd19840,
      24'd22351, 24'd25057, 24'd27966, 24'd31083, 24'd34415, 24'd37968, 24'd41749, 24'd45763,
      24'd50018, 24'd54518, 24'd59271, 24'd64283, 24'd69559, 24'd75105, 24'd80928, 24'd87033,
      24'd93427, 24'd100115, 24'd107103, 24'd114398, 24'd122004, 24'd129927, 24'd138175,
      24'd146751,
      24'd155662, 24'd164913, 24'd174511, 24'd184460, 24'd194767, 24'd205437, 24'd216476,
      24'd227888,
      24'd239681, 24'd251858, 24'd264427, 24'd277391, 24'd290757, 24'd304530, 24'd318716,
      24'd333319,
      24'd348346, 24'd363801, 24'd379691, 24'd396019, 24'd412793, 24'd430016, 24'd447694,
      24'd465833,
      24'd484438, 24'd503514, 24'd523065, 24'd543099, 24'd563619, 24'd584630, 24'd606139,
      24'd628150,
      24'd650668, 24'd673698, 24'd697246, 24'd721317, 24'd745915, 24'd771046, 24'd796715,
      24'd822927,
      24'd849687, 24'd877000, 24'd904870, 24'd933304, 24'd962306, 24'd991881, 24'd1022034,
      24'd1052770,
      24'd1084094, 24'd1116010, 24'd1148525, 24'd1181642, 24'd1215367, 24'd1249704,
      24'd1284659, 24'd1320236,
      24'd1356441, 24'd1393277, 24'd1430750, 24'd1468866, 24'd1507627, 24'd1547040,
      24'd1587110, 24'd1627840,
      24'd1669237, 24'd1711304, 24'd1754046, 24'd1797469, 24'd1841577, 24'd1886374,
      24'd1931867, 24'd1978058,
      24'd2024953, 24'd2072557, 24'd2120875, 24'd2169910, 24'd2219669, 24'd2270155,
      24'd2321374, 24'd2373329,
      24'd2426026, 24'd2479469, 24'd2533663, 24'd2588613, 24'd2644323, 24'd2700798,
      24'd2758043, 24'd2816061,
      24'd2874859, 24'd2934439, 24'd2994808, 24'd3055969, 24'd3117928, 24'd3180688,
      24'd3244254, 24'd3308632,
      24'd3373825, 24'd3439838, 24'd3506675, 24'd3574342, 24'd3642842, 24'd3712181,
      24'd3782362, 24'd3853390,
      24'd3925271, 24'd3998007, 24'd4071604, 24'd4146067, 24'd4221399, 24'd4297606,
      24'd4374691, 24'd4452660,
      24'd4531516, 24'd4611264, 24'd4691909, 24'd4773455, 24'd4855907, 24'd4939268,
      24'd5023544, 24'd5108739,
      24'd5194856, 24'd5281902, 24'd5369880, 24'd5458794, 24'd5548649, 24'd5639449,
      24'd5731199, 24'd5823903,
      24'd5917565, 24'd6012190, 24'd6107783, 24'd6204347, 24'd6301887, 24'd6400407,
      24'd6499912, 24'd6600406,
      24'd6701893, 24'd6804378, 24'd6907865, 24'd7012358, 24'd7117862, 24'd7224381,
      24'd7331919, 24'd7440481,
      24'd7550071, 24'd7660693, 24'd7772351, 24'd7885051, 24'd7998795, 24'd8113589,
      24'd8229437, 24'd8346342,
      24'd8464310, 24'd8583344, 24'd8703450, 24'd8824630, 24'd8946889, 24'd9070232,
      24'd9194663, 24'd9320185,
      24'd9446804, 24'd9574524, 24'd9703348, 24'd9833281, 24'd9964328, 24'd10096491,
      24'd10229777, 24'd10364188,
      24'd10499729, 24'd10636404, 24'd10774218, 24'd10913175, 24'd11053278, 24'd11194532,
      24'd11336942, 24'd11480511,
      24'd11625243, 24'd11771143, 24'd11918215, 24'd12066463, 24'd12215891, 24'd12366504,
      24'd12518305, 24'd12671299,
      24'd12825489, 24'd12980881, 24'd13137478, 24'd13295284, 24'd13454303, 24'd13614540,
      24'd13775998, 24'd13938682,
      24'd14102596, 24'd14267744, 24'd14434130, 24'd14601758, 24'd14770633, 24'd14940758,
      24'd15112137, 24'd15284775,
      24'd15458676, 24'd15633844, 24'd15810282, 24'd15987995, 24'd16166988, 24'd16347263,
      24'd16528826, 24'd16711680
   };

   function automatic logic [7:0] gamma8(input logic [7:0] x);
      logic [23:0] entry;
      entry  = GAMMA_CURVE[x];
      gamma8 = entry[23:16];
   endfunction

endpackage

// ----- src/rgbled_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rgbled_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/rgbled_ctrl.sv -----
// Controller: accepts items and sequences the pixel load wait.
module rgbled_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  rgbled_pkg::dp_status_type status,
   output rgbled_pkg::dp_cmd_type    cmd,
   output logic                     busy
);
   import rgbled_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   assign accept = start && (state_ff == CTL_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (accept && status.need_load) begin
               state_in = CTL_LOAD;
            end
         end
         CTL_LOAD: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.take        = 1'b0;
      cmd.issue_read  = 1'b0;
      cmd.finish_load = 1'b0;
      busy            = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            cmd.take       = accept && !status.need_load;
            cmd.issue_read = accept && status.need_load;
         end
         CTL_LOAD: begin
            cmd.finish_load = 1'b1;
            busy            = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/rgbled_dp.sv -----
// Datapath: registers, frame counters, pixel store, gamma and result registers.
module rgbled_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rgbled_pkg::dp_cmd_type cmd,
   output rgbled_pkg::dp_status_type status,
   input  logic [2:0]             req_op,
   input  logic [5:0]             req_led_index,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_strobe,
   output logic                   rsp_accepted,
   output logic [7:0]             rsp_high_ticks,
   output logic                   rsp_busy_res,
   output logic                   rsp_frame_done
);
   import rgbled_pkg::*;

   logic [7:0]            high_one_ff;
   logic [7:0]            high_zero_ff;
   logic [7:0]            reset_per_ff;
   logic [6:0]            led_count_ff;

   logic                  front_ff, front_in;
   logic                  pending_ff, pending_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            reset_left_ff, reset_left_in;
   logic [LED_POS_W-1:0]  led_pos_ff, led_pos_in;
   logic [BIT_POS_W-1:0]  bit_pos_ff, bit_pos_in;
   logic [23:0]           shift_ff, shift_in;

   logic [RAM_DEPTH-1:0]  valid_ff, valid_in;
   logic                  valid_rd_ff;

   logic                  strobe_ff, strobe_in;
   logic                  accepted_ff, accepted_in;
   logic [7:0]            high_ff, high_in;
   logic                  busy_res_ff;
   logic                  done_ff, done_in;

   logic [CNT_W-1:0]      active_cnt;
   logic [CNT_W-1:0]      led_count_ext;
   logic [LED_POS_W-1:0]  pos_clamped;
   logic [RAM_ADDR_W-1:0] raddr;
   logic [RAM_ADDR_W-1:0] waddr;
   logic                  ram_we;
   logic [23:0]           ram_q;
   logic [23:0]           pixel;
   logic [23:0]           loaded;
   logic [23:0]           cur_word;
   logic [7:0]            tick_high;
   logic [LED_POS_W-1:0]  led_next;
   logic                  led_last_bit;
   logic                  frame_end;
   logic                  idx_ok;
   logic                  wr_half;

   assign led_count_ext = CNT_W'(led_count_ff);
   assign active_cnt = (led_count_ff == 7'd0) ? CNT_W'(1) :
                       (led_count_ext > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_ext;

   assign idx_ok  = CNT_W'(req_led_index) < active_cnt;
   assign wr_half = (req_op == OP_WR_FRONT) ? front_ff : ~front_ff;
   assign waddr   = {wr_half, LED_ADDR_W'(req_led_index)};

   assign pos_clamped = (led_pos_ff >= LED_POS_W'(MAX_LEDS)) ? LED_POS_W'(MAX_LEDS - 1)
                                                              : led_pos_ff;
   assign raddr = {front_ff, pos_clamped[LED_ADDR_W-1:0]};

   rgbled_ram #(
      .WIDTH (24),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata ({req_red, req_green, req_blue}),
      .raddr (raddr),
      .rdata (ram_q)
   );

   // unwritten entries read as zero
   assign pixel  = valid_rd_ff ? ram_q : 24'd0;
   assign loaded = {gamma8(pixel[15:8]), gamma8(pixel[23:16]), gamma8(pixel[7:0])};

   assign cur_word     = cmd.finish_load ? loaded : shift_ff;
   assign tick_high    = cur_word[23] ? high_one_ff : high_zero_ff;
   assign led_last_bit = (bit_pos_ff == BIT_POS_W'(BITS_PER_PIXEL - 1));
   assign led_next     = led_pos_ff + LED_POS_W'(1);
   assign frame_end    = CNT_W'(led_next) >= active_cnt;

   assign status.need_load = (req_op == OP_TICK) && (phase_ff == PH_DATA) &&
                             (bit_pos_ff == '0);

   always_comb begin
      front_in      = front_ff;
      pending_in    = pending_ff;
      phase_in      = phase_ff;
      reset_left_in = reset_left_ff;
      led_pos_in    = led_pos_ff;
      bit_pos_in    = bit_pos_ff;
      shift_in      = shift_ff;
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      strobe_in     = 1'b0;
      accepted_in   = 1'b0;
      high_in       = 8'd0;
      done_in       = 1'b0;

      if (cmd.take) begin
         strobe_in = 1'b1;
         case (req_op)
            OP_WR_FRONT, OP_WR_BACK: begin
               if (idx_ok) begin
                  ram_we          = 1'b1;
                  valid_in[waddr] = 1'b1;
                  accepted_in     = 1'b1;
               end
            end
            OP_COMMIT: begin
               pending_in = 1'b1;
            end
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  if (pending_ff) begin
                     front_in   = ~front_ff;
                     pending_in = 1'b0;
                  end
                  reset_left_in = (reset_per_ff == 8'd0) ? 8'd1 : reset_per_ff;
                  led_pos_in    = '0;
                  bit_pos_in    = '0;
                  phase_in      = PH_RESET;
                  accepted_in   = 1'b1;
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_RESET) begin
                  reset_left_in = reset_left_ff - 8'd1;
                  if (reset_left_ff == 8'd1) begin
                     phase_in   = PH_DATA;
                     led_pos_in = '0;
                     bit_pos_in = '0;
                  end
               end else if (phase_ff == PH_DATA) begin
                  high_in  = tick_high;
                  shift_in = {cur_word[22:0], 1'b0};
                  if (led_last_bit) begin
                     bit_pos_in = '0;
                     led_pos_in = led_next;
                     if (frame_end) begin
                        phase_in   = PH_IDLE;
                        led_pos_in = '0;
                        done_in    = 1'b1;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff + BIT_POS_W'(1);
                  end
               end
            end
            default: begin
               strobe_in = 1'b1;
            end
         endcase
      end

      // first bit of an LED: the pixel word arrived from the store this cycle
      if (cmd.finish_load) begin
         strobe_in  = 1'b1;
         high_in    = tick_high;
         shift_in   = {cur_word[22:0], 1'b0};
         bit_pos_in = bit_pos_ff + BIT_POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_one_ff   <= 8'd60;
         high_zero_ff  <= 8'd30;
         reset_per_ff  <= 8'd35;
         led_count_ff  <= 7'd64;
         front_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         phase_ff      <= PH_IDLE;
         reset_left_ff <= 8'd0;
         led_pos_ff    <= '0;
         bit_pos_ff    <= '0;
         valid_ff      <= '0;
         strobe_ff     <= 1'b0;
         accepted_ff   <= 1'b0;
         high_ff       <= 8'd0;
         busy_res_ff   <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HIGH_ONE:  high_one_ff  <= csr_wdata;
               CSR_HIGH_ZERO: high_zero_ff <= csr_wdata;
               CSR_RESET_PER: reset_per_ff <= csr_wdata;
               CSR_LED_COUNT: led_count_ff <= csr_wdata[6:0];
               default:       led_count_ff <= led_count_ff;
            endcase
         end
         front_ff      <= front_in;
         pending_ff    <= pending_in;
         phase_ff      <= phase_in;
         reset_left_ff <= reset_left_in;
         led_pos_ff    <= led_pos_in;
         bit_pos_ff    <= bit_pos_in;
         valid_ff      <= valid_in;
         strobe_ff     <= strobe_in;
         accepted_ff   <= accepted_in;
         high_ff       <= high_in;
         busy_res_ff   <= strobe_in && (phase_in != PH_IDLE);
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (cmd.issue_read) begin
         valid_rd_ff <= valid_ff[raddr];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_high_ticks = high_ff;
   assign rsp_busy_res   = busy_res_ff;
   assign rsp_frame_done = done_ff;

endmodule

// ----- src/rgb_led_strip_driver_top.sv -----
// Top level of the RGB LED strip driver: controller, datapath and checks.
//
//  channel   ports                                 transfer
//  request   start, busy, req_*                    start && !busy at clock edge
//  response  rsp_strobe, rsp_*                     one cycle wide, no back-pressure
//  csr       csr_we, csr_index, csr_wdata          csr_we at clock edge
//
// Most items give their result on rsp_* in the cycle after they are taken.
// A tick that sends the first bit of an LED waits for the pixel store: the
// read is registered, so busy is high for one cycle while the word arrives and
// its result follows that wait, later than for other items.
// Every other item is taken without a wait, so a new item may follow right away.
// Reset is synchronous; the pixel store reads as zero until each entry is written.
module rgb_led_strip_driver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [5:0] req_led_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output logic       rsp_strobe,
   output logic       rsp_accepted,
   output logic [7:0] rsp_high_ticks,
   output logic       rsp_busy_res,
   output logic       rsp_frame_done
);
   import rgbled_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rgbled_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   rgbled_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_led_index  (req_led_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_accepted   (rsp_accepted),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done)
   );

`ifndef NO_ASSERTIONS
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("pixel load wait lasted more than one cycle");

   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("no result after pixel load");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_frame_done |-> (rsp_strobe && !rsp_busy_res))
      else $error("frame done while still busy");

   a_fields_only_with_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_accepted || (rsp_high_ticks != 8'd0)) |-> rsp_strobe)
      else $error("result field set without strobe");
`endif

endmodule

// ----- sim/led_chain_scoreboard.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RGB LED strip driver: mirrors its state, predicts and compares responses.
module led_chain_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_op,
   input  logic [5:0]  req_led_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        rsp_strobe,
   input  logic        rsp_accepted,
   input  logic [7:0]  rsp_high_ticks,
   input  logic        rsp_busy_res,
   input  logic        rsp_frame_done,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   import rgbled_pkg::*;

   typedef struct packed {
      logic       accepted;
      logic [7:0] high_ticks;
      logic       busy_res;
      logic       frame_done;
   } pulse_type;

   logic [23:0] pixel_mem [0:RAM_DEPTH-1];
   logic        front_sel;
   logic        commit_mark;
   phase_type   ph;
   logic [7:0]  low_left;
   logic [6:0]  led_pos;
   logic [4:0]  bit_pos;
   logic [23:0] color_word;

   logic [7:0]  t_one;
   logic [7:0]  t_zero;
   logic [7:0]  low_periods;
   logic [6:0]  led_total;

   pulse_type   awaited_pulses [$];

   function automatic int eff_leds();
      int n;
      n = int'(led_total);
      if (n == 0) n = 1;
      if (n > MAX_LEDS) n = MAX_LEDS;
      return n;
   endfunction

   function automatic logic [7:0] corrected(input logic [7:0] c);
      logic [23:0] entry;
      entry = GAMMA_CURVE[c];
      return entry[23:16];
   endfunction

   task automatic chain_step(input logic [2:0] op, input logic [5:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, output pulse_type res);
      int          half;
      int          pos;
      logic [23:0] raw;
      res = '0;
      case (op)
         OP_WR_FRONT, OP_WR_BACK: begin
            if (int'(idx) < eff_leds()) begin
               half = ((op == OP_WR_FRONT) ? front_sel : !front_sel) ? 1 : 0;
               pixel_mem[half * MAX_LEDS + int'(idx)] = {r, g, b};
               res.accepted = 1'b1;
            end
         end
         OP_COMMIT: commit_mark = 1'b1;
         OP_START: begin
            if (ph == PH_IDLE) begin
               if (commit_mark) begin
                  front_sel   = !front_sel;
                  commit_mark = 1'b0;
               end
               low_left     = (low_periods == 8'd0) ? 8'd1 : low_periods;
               led_pos      = '0;
               bit_pos      = '0;
               ph           = PH_RESET;
               res.accepted = 1'b1;
            end
         end
         OP_TICK: begin
            if (ph == PH_RESET) begin
               low_left = low_left - 8'd1;
               if (low_left == 8'd0) begin
                  ph      = PH_DATA;
                  led_pos = '0;
                  bit_pos = '0;
               end
            end else if (ph == PH_DATA) begin
               if (bit_pos == 5'd0) begin
                  pos = (int'(led_pos) >= MAX_LEDS) ? MAX_LEDS - 1 : int'(led_pos);
                  raw = pixel_mem[(front_sel ? MAX_LEDS : 0) + pos];
                  // wire order is green, red, blue
                  color_word = {corrected(raw[15:8]), corrected(raw[23:16]),
                                corrected(raw[7:0])};
               end
               res.high_ticks = color_word[23] ? t_one : t_zero;
               color_word     = color_word << 1;
               bit_pos        = bit_pos + 5'd1;
               if (int'(bit_pos) >= BITS_PER_PIXEL) begin
                  bit_pos = '0;
                  led_pos = led_pos + 7'd1;
                  if (int'(led_pos) >= eff_leds()) begin
                     ph             = PH_IDLE;
                     led_pos        = '0;
                     res.frame_done = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      res.busy_res = (ph != PH_IDLE);
   endtask

   task automatic flag(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pulse_type want;
      pulse_type got;
      pulse_type res;
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) pixel_mem[i] = '0;
         front_sel   = 1'b0;
         commit_mark = 1'b0;
         ph          = PH_IDLE;
         low_left    = '0;
         led_pos     = '0;
         bit_pos     = '0;
         color_word  = '0;
         t_one       = 8'd60;
         t_zero      = 8'd30;
         low_periods = 8'd35;
         led_total   = 7'd64;
         awaited_pulses.delete();
         fail_count  = 0;
      end else begin
         if (rsp_strobe) begin
            got = {rsp_accepted, rsp_high_ticks, rsp_busy_res, rsp_frame_done};
            if (awaited_pulses.size() == 0) begin
               $display("%0t ns: response with no transfer outstanding", $time);
               fail_count++;
            end else begin
               want = awaited_pulses.pop_front();
               if (got.accepted !== want.accepted)
                  flag("accepted", 8'(want.accepted), 8'(got.accepted));
               if (got.high_ticks !== want.high_ticks)
                  flag("high_ticks", want.high_ticks, got.high_ticks);
               if (got.busy_res !== want.busy_res)
                  flag("busy_res", 8'(want.busy_res), 8'(got.busy_res));
               if (got.frame_done !== want.frame_done)
                  flag("frame_done", 8'(want.frame_done), 8'(got.frame_done));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HIGH_ONE:  t_one       = csr_wdata;
               CSR_HIGH_ZERO: t_zero      = csr_wdata;
               CSR_RESET_PER: low_periods = csr_wdata;
               CSR_LED_COUNT: led_total   = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            chain_step(req_op, req_led_index, req_red, req_green, req_blue, res);
            awaited_pulses.push_back(res);
         end
      end
      pending_count = awaited_pulses.size();
   end

endmodule

// ----- sim/tb_rgb_led_strip_driver_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the RGB LED strip driver: clock, reset, stimulus and verdict.
module tb_rgb_led_strip_driver_top;
   import rgbled_pkg::*;

   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 30;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [5:0]  req_led_index;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        rsp_strobe;
   logic        rsp_accepted;
   logic [7:0]  rsp_high_ticks;
   logic        rsp_busy_res;
   logic        rsp_frame_done;

   int unsigned fail_count;
   int unsigned pending_count;
   logic        taken;
   logic [7:0]  cfg_low;
   logic [6:0]  cfg_leds;
   int          sent;
   bit          quiet;

   rgb_led_strip_driver_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_led_index  (req_led_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_accepted   (rsp_accepted),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done)
   );

   led_chain_scoreboard chain_sb (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_led_index  (req_led_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_accepted   (rsp_accepted),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) taken <= !reset && start && !busy;

   initial begin
      #2_000_000;
      $display("rgb_led_strip_driver_top verification failed");
      $finish;
   end

   function automatic int leds_eff();
      int n;
      n = int'(cfg_leds);
      if (n == 0) n = 1;
      if (n > MAX_LEDS) n = MAX_LEDS;
      return n;
   endfunction

   function automatic logic [5:0] pick_index();
      if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, leds_eff() - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   // one transfer, then an occasional burst of idle cycles
   task automatic send(input logic [2:0] op, input logic [5:0] idx,
                       input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      start         <= 1'b1;
      req_op        <= op;
      req_led_index <= idx;
      req_red       <= r;
      req_green     <= g;
      req_blue      <= b;
      @(negedge clock);
      while (!taken) @(negedge clock);
      sent++;
      if (!quiet && $urandom_range(0, 99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_op(input logic [2:0] op);
      send(op, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_RESET_PER) cfg_low = data;
      if (idx == CSR_LED_COUNT) cfg_leds = data[6:0];
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] one_t, input logic [7:0] zero_t,
                             input logic [7:0] low_n, input logic [6:0] leds);
      csr_put(CSR_HIGH_ONE, one_t);
      csr_put(CSR_HIGH_ZERO, zero_t);
      csr_put(CSR_RESET_PER, low_n);
      csr_put(CSR_LED_COUNT, {1'b0, leds});
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // load up to four pixels, maybe commit, start, then mostly ticks with writes, starts and commits mixed in
   task automatic play_frame();
      int len;
      int k;
      repeat ($urandom_range(0, 4))
         send(3'($urandom_range(0, 1)), pick_index(), 8'($urandom), 8'($urandom),
              8'($urandom));
      if ($urandom_range(0, 1) == 1) send_op(OP_COMMIT);
      send_op(OP_START);
      len = ((cfg_low == 8'd0) ? 1 : int'(cfg_low)) + BITS_PER_PIXEL * leds_eff();
      if (len > 300) len = $urandom_range(30, 120);
      len = len + $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         k = $urandom_range(0, 99);
         if (k < 6)
            send(OP_WR_FRONT, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom));
         else if (k < 8)
            send(OP_WR_BACK, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom));
         else if (k < 9)
            send_op(OP_START);
         else if (k < 10)
            send_op(OP_COMMIT);
         else
            send_op(OP_TICK);
      end
   endtask

   initial begin
      int target;
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = '0;
      req_led_index = '0;
      req_red       = '0;
      req_green     = '0;
      req_blue      = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      cfg_low       = 8'd35;
      cfg_leds      = 7'd64;
      sent          = 0;
      quiet         = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      csr_put(CSR_RESET_PER, 8'd0);
      csr_put(CSR_LED_COUNT, 8'd2);
      csr_we <= 1'b0;
      send_op(OP_TICK);
      send(OP_WR_FRONT, 6'd0, 8'hff, 8'h00, 8'h80);
      send(OP_WR_FRONT, 6'd1, 8'h00, 8'hff, 8'h01);
      send(OP_WR_FRONT, 6'd2, 8'hff, 8'hff, 8'hff);
      send(OP_WR_BACK, 6'd63, 8'hff, 8'hff, 8'hff);
      send(OP_WR_BACK, 6'd0, 8'h80, 8'hff, 8'h00);
      send_op(3'd5);
      send_op(3'd6);
      send_op(3'd7);
      send_op(OP_START);
      send_op(OP_START);
      send_op(OP_COMMIT);
      send_op(OP_TICK);
      repeat (4) send_op(OP_TICK);
      send(OP_WR_FRONT, 6'd1, 8'h7f, 8'h01, 8'hfe);
      repeat (3) send_op(OP_TICK);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: set_config(8'd255, 8'd0, 8'd0, 7'd0);
            1: set_config(8'd0, 8'd255, 8'd2, 7'd127);
            2: set_config(8'($urandom), 8'($urandom), 8'd255, 7'd1);
            3: set_config(8'($urandom), 8'($urandom), 8'd1, 7'd64);
            default: set_config(8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)),
                                7'($urandom_range(1, 5)));
         endcase
         quiet  = (p == PHASES - 1);
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            if ($urandom_range(0, 99) < 75)
               play_frame();
            else
               send(3'($urandom_range(0, 7)), 6'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
         end
      end

      start <= 1'b0;
      for (int w = 0; w < 2000 && pending_count != 0; w++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("rgb_led_strip_driver_top verification clean");
      else
         $display("rgb_led_strip_driver_top verification failed");
      $finish;
   end

endmodule
